>>> hw/rtl/hsfs_pkg.sv
package hsfs_pkg;

  localparam int NumStates  = 4;
  localparam int ValueBits  = 32;
  localparam int FracBits   = ValueBits - 2;
  localparam int IdxBits    = $clog2(NumStates);
  localparam int ProdBits   = 2 * ValueBits;
  localparam logic [ValueBits-1:0] ValMax = {ValueBits{1'b1}};

  typedef enum logic [1:0] {
    ACT_TRANS = 2'd0,
    ACT_INIT  = 2'd1,
    ACT_EMIS  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_EMIS,
    ST_DIV,
    ST_OUT
  } state_e;

  // Truncate a full product to the format and saturate.
  function automatic logic [ValueBits-1:0] fix_trunc(input logic [ProdBits-1:0] p);
    logic [ProdBits-1:0] s;
    s = p >> FracBits;
    if (s > ProdBits'(ValMax)) fix_trunc = ValMax;
    else fix_trunc = s[ValueBits-1:0];
  endfunction

  function automatic logic [ValueBits-1:0] sat_add(input logic [ValueBits-1:0] a,
                                                   input logic [ValueBits-1:0] b);
    logic [ValueBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[ValueBits] ? ValMax : s[ValueBits-1:0];
  endfunction

endpackage

>>> hw/rtl/hsfs_cell.sv
// One state cell: holds a transition row, initial prob, emission and previous
// normalized value; accumulates its prior from the shared vector and shifts it along the chain.
module hsfs_cell import hsfs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_trans_i,
  input  logic                 wr_init_i,
  input  logic                 wr_emis_i,
  input  logic [IdxBits-1:0]   col_i,
  input  logic [ValueBits-1:0] value_i,
  input  logic                 clr_i,
  input  logic                 mac_i,
  input  logic [IdxBits-1:0]   mac_col_i,
  input  logic [ValueBits-1:0] vec_i,
  input  logic                 emis_i,
  input  logic                 norm_wr_i,
  input  logic [ValueBits-1:0] norm_i,
  input  logic                 shift_i,
  input  logic [ValueBits-1:0] shift_in_i,
  output logic [ValueBits-1:0] shift_o,
  output logic [ValueBits-1:0] init_o,
  output logic [ValueBits-1:0] prev_o
);

  logic [ValueBits-1:0] trans_q [NumStates];
  logic [ValueBits-1:0] init_q, emis_q, acc_q, prev_q;
  logic [ProdBits-1:0]  prod_q;
  logic                 prod_v_q;
  logic                 emis_v_q;

  // Hold the tables written by load transactions.
  always_ff @(posedge clk_i) begin
    if (wr_trans_i) trans_q[col_i] <= value_i;
    if (wr_init_i) init_q <= value_i;
    if (wr_emis_i) emis_q <= value_i;
  end

  // Delay the multiply strobes so the accumulate follows in the next cycle; hold the previous normalized value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      emis_v_q <= 1'b0;
      prev_q   <= '0;
    end else begin
      prod_v_q <= mac_i;
      emis_v_q <= emis_i;
      if (norm_wr_i) prev_q <= norm_i;
    end
  end

  // Clear, accumulate, or shift; the emission product replaces the prior in the cycle after the multiply.
  always_ff @(posedge clk_i) begin
    if (mac_i) prod_q <= ProdBits'(trans_q[mac_col_i]) * ProdBits'(vec_i);
    else if (emis_i) prod_q <= ProdBits'(acc_q) * ProdBits'(emis_q);
    if (clr_i) acc_q <= '0;
    else if (prod_v_q) acc_q <= sat_add(acc_q, fix_trunc(prod_q));
    else if (emis_v_q) acc_q <= fix_trunc(prod_q);
    else if (shift_i) acc_q <= shift_in_i;
  end

  assign shift_o = acc_q;
  assign init_o  = init_q;
  assign prev_o  = prev_q;

endmodule

>>> hw/rtl/hsfs_div.sv
// Restoring fractional divider: one quotient bit per cycle, num <= den.
module hsfs_div import hsfs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [ValueBits-1:0] num_i,
  input  logic [ValueBits-1:0] den_i,
  output logic                 done_o,
  output logic [ValueBits-1:0] quo_o
);

  localparam int CntBits = $clog2(FracBits + 2);

  logic [ValueBits:0]   rem_q;
  logic [ValueBits-1:0] den_q, quo_q;
  logic [CntBits-1:0]   cnt_q;
  logic                 busy_q;
  logic                 done_q;
  logic [ValueBits+1:0] rsh;

  assign rsh = {rem_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntBits'(FracBits - 1)) busy_q <= 1'b0;
    end
  end

  // Flag done once the last quotient bit has landed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CntBits'(FracBits - 1));
    end
  end

  // Shift, compare, subtract.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      if (num_i >= den_i && den_i != '0) begin
        rem_q <= {1'b0, num_i - den_i};
        quo_q <= ValueBits'(1);
      end else begin
        rem_q <= {1'b0, num_i};
        quo_q <= '0;
      end
    end else if (busy_q) begin
      if (rsh >= (ValueBits+2)'(den_q)) begin
        rem_q <= (ValueBits+1)'(rsh - (ValueBits+2)'(den_q));
        quo_q <= {quo_q[ValueBits-2:0], 1'b1};
      end else begin
        rem_q <= rsh[ValueBits:0];
        quo_q <= {quo_q[ValueBits-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

>>> hw/rtl/hmm_scaled_forward_step.sv
// Load transactions give no result.
// Closing emission: the prior MACs, then the emission products and scale, then per state
// a serial divide (skipped on a zero scale) and an output handshake.
// Input is held off until the last result of the site is taken.
// Reset: prev_norm cleared, site flag set; tables undefined until written.
module hmm_scaled_forward_step import hsfs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic [1:0]           action_i,
  input  logic [1:0]           row_i,
  input  logic [1:0]           col_i,
  input  logic [31:0]          value_i,
  input  logic                 first_site_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [1:0]           state_index_o,
  output logic [31:0]          norm_lik_o,
  output logic [31:0]          site_scale_o,
  output logic                 zero_scale_o,
  output logic                 last_o
);

  localparam int CntBits = $clog2(NumStates + 3);

  state_e state_q, state_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 first_q;
  logic [ValueBits-1:0] scale_q, norm_q;
  logic [IdxBits-1:0]   idx_q;
  logic                 zero_q;

  logic acc;
  logic in_range, close;
  logic [ValueBits-1:0] val_sat;

  logic [ValueBits-1:0] chain [NumStates+1];
  logic [ValueBits-1:0] init_v [NumStates];
  logic [ValueBits-1:0] prev_v [NumStates];
  logic [ValueBits-1:0] vec;
  logic [IdxBits-1:0]   mac_col;
  logic mac, emis, clr, shift, div_start, div_done;
  logic [ValueBits-1:0] div_q;
  logic [ValueBits-1:0] scale_sum;

  assign ready_o  = (state_q == ST_IDLE);
  assign acc      = valid_i && ready_o;
  assign in_range = (32'(row_i) < NumStates) && (32'(col_i) < NumStates);
  assign val_sat  = (value_i > 32'(ValMax)) ? ValMax : ValueBits'(value_i);
  assign close    = acc && (action_i == ACT_EMIS) && (32'(row_i) < NumStates)
                    && (row_i == IdxBits'(NumStates - 1));

  assign mac_col = cnt_q[IdxBits-1:0];
  assign vec     = first_q ? init_v[mac_col] : prev_v[mac_col];
  assign mac     = (state_q == ST_MAC) && (32'(cnt_q) < NumStates);
  assign emis    = (state_q == ST_EMIS) && (cnt_q == '0);
  assign clr     = close;
  assign shift   = (state_q == ST_OUT) && valid_o && ready_i;
  assign chain[NumStates] = '0;

  // Build the chain of state cells; accumulators shift toward cell zero.
  for (genvar g = 0; g < NumStates; g++) begin : g_cell
    hsfs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_trans_i (acc && action_i == ACT_TRANS && in_range && row_i == IdxBits'(g)),
      .wr_init_i  (acc && action_i == ACT_INIT && 32'(row_i) < NumStates
                   && row_i == IdxBits'(g)),
      .wr_emis_i  (acc && action_i == ACT_EMIS && 32'(row_i) < NumStates
                   && row_i == IdxBits'(g)),
      .col_i      (col_i[IdxBits-1:0]),
      .value_i    (val_sat),
      .clr_i      (clr),
      .mac_i      (mac),
      .mac_col_i  (mac_col),
      .vec_i      (vec),
      .emis_i     (emis),
      .norm_wr_i  (shift && idx_q == IdxBits'(g)),
      .norm_i     (norm_q),
      .shift_i    (shift),
      .shift_in_i (chain[g+1]),
      .shift_o    (chain[g]),
      .init_o     (init_v[g]),
      .prev_o     (prev_v[g])
    );
  end

  hsfs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (chain[0]),
    .den_i   (scale_q),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  // Sequence the site update.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    div_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (close) state_d = ST_MAC;
      end
      ST_MAC: begin
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) == NumStates) begin
          state_d = ST_EMIS;
          cnt_d   = '0;
        end
      end
      ST_EMIS: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntBits'(2)) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        if (zero_q) begin
          state_d = ST_OUT;
        end else if (cnt_q == '0) begin
          div_start = 1'b1;
          cnt_d     = CntBits'(1);
        end else if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (valid_o && ready_i) begin
          cnt_d   = '0;
          state_d = (idx_q == IdxBits'(NumStates - 1)) ? ST_IDLE : ST_DIV;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      first_q <= 1'b1;
      idx_q   <= '0;
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (acc && action_i == ACT_EMIS && 32'(row_i) < NumStates && first_site_i)
        first_q <= 1'b1;
      if (state_q == ST_EMIS && cnt_q == CntBits'(2)) first_q <= 1'b0;
      if (close) idx_q <= '0;
      else if (shift) idx_q <= idx_q + 1'b1;
      if (shift) valid_o <= 1'b0;
      else if (state_q == ST_DIV && state_d == ST_OUT) valid_o <= 1'b1;
    end
  end

  // Add up the emission products held in the cells.
  always_comb begin
    scale_sum = '0;
    for (int k = 0; k < NumStates; k++) scale_sum = sat_add(scale_sum, chain[k]);
  end

  // Latch the scale after the emission products land in the cells.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIS && cnt_q == CntBits'(2)) begin
      scale_q <= scale_sum;
      zero_q  <= (scale_sum == '0);
    end
    if (state_q == ST_DIV && state_d == ST_OUT) norm_q <= zero_q ? '0 : div_q;
  end

  assign state_index_o = idx_q;
  assign norm_lik_o    = norm_q;
  assign site_scale_o  = scale_q;
  assign zero_scale_o  = zero_q;
  assign last_o        = (idx_q == IdxBits'(NumStates - 1));

endmodule
